[hw/rtl/mau_pkg.sv]
package mau_pkg;

  localparam int unsigned DataWidth = 32;

  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_POW  = 3'd3,
    CMD_INVA = 3'd4,
    CMD_INVB = 3'd5,
    CMD_DIVA = 3'd6,
    CMD_DIVB = 3'd7
  } cmd_e;

  typedef struct packed {
    logic [2:0]           cmd;
    logic [DataWidth-1:0] operand_a;
    logic [DataWidth-1:0] operand_b;
  } in_word_t;

  typedef struct packed {
    logic [DataWidth-1:0] result;
    logic                 no_inverse;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_B,
    ST_DISPATCH,
    ST_POW_MUL,
    ST_POW_SQR,
    ST_INV_DIV,
    ST_INV_MUL,
    ST_INV_NEXT,
    ST_FINAL_MUL,
    ST_DONE
  } state_e;

endpackage

[hw/rtl/mau_fifo.sv]
module mau_fifo
  import mau_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     wr_i,
  input  in_word_t wdata_i,
  output logic     full_o,
  input  logic     rd_i,
  output logic     empty_o,
  output in_word_t rdata_o
);

  in_word_t   mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_i) begin
        wp_q <= ~wp_q;
      end
      if (rd_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, wr_i} - {1'b0, rd_i};
    end
  end

endmodule

[hw/rtl/mau_mulmod.sv]
// Bit-serial modular multiply: one doubling and conditional add per cycle.
module mau_mulmod #(
  parameter int unsigned Width = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] x_i,
  input  logic [Width-1:0] y_i,
  input  logic [Width-1:0] m_i,
  output logic             done_o,
  output logic [Width-1:0] p_o
);

  localparam int unsigned CntW = $clog2(Width + 1);

  logic [Width-1:0] acc_q, acc_d, y_q, x_q, dbl, sum;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;

  function automatic logic [Width-1:0] addm(logic [Width-1:0] u, logic [Width-1:0] v,
                                           logic [Width-1:0] m);
    logic [Width-1:0] t;
    t = m - v;
    return (u >= t) ? (u - t) : (u + v);
  endfunction

  always_comb begin
    dbl   = addm(acc_q, acc_q, m_i);
    sum   = addm(dbl, x_q, m_i);
    acc_d = y_q[Width-1] ? sum : dbl;
  end

  assign p_o = acc_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      x_q   <= x_i;
      y_q   <= y_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      y_q   <= {y_q[Width-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= busy_q && !start_i && (cnt_q == CntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(Width);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule

[hw/rtl/mau_divmod.sv]
// Restoring divider, one quotient bit per cycle.
module mau_divmod #(
  parameter int unsigned Width = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [Width-1:0] n_i,
  input  logic [Width-1:0] d_i,
  output logic             done_o,
  output logic [Width-1:0] q_o,
  output logic [Width-1:0] r_o
);

  localparam int unsigned CntW = $clog2(Width + 1);

  logic [Width-1:0] n_q, d_q, r_q;
  logic [Width:0]   trial;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;

  assign trial = {r_q, n_q[Width-1]};
  assign q_o   = n_q;
  assign r_o   = r_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= n_i;
      d_q <= d_i;
      r_q <= '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, d_q}) begin
        r_q <= Width'(trial - {1'b0, d_q});
        n_q <= {n_q[Width-2:0], 1'b1};
      end else begin
        r_q <= trial[Width-1:0];
        n_q <= {n_q[Width-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= busy_q && !start_i && (cnt_q == CntW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(Width);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule

[hw/rtl/mau_core.sv]
module mau_core
  import mau_pkg::*;
#(
  parameter int unsigned Width = DataWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  in_word_t         word_i,
  input  logic [Width-1:0] m_i,
  output logic             busy_o,
  output logic             done_o,
  output out_word_t        res_o
);

  state_e state_q, state_d;
  cmd_e   cmd_q;
  logic [Width-1:0] a_q, b_q, e_q, base_q, acc_q, m_q;
  logic [Width-1:0] r0_q, r1_q, t0_q, t1_q;
  logic             err_q;

  logic             mul_start, div_start, mul_done, div_done;
  logic [Width-1:0] mul_x, mul_y, mul_p, div_n, div_d, div_qt, div_r;

  mau_mulmod #(.Width(Width)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .x_i(mul_x), .y_i(mul_y), .m_i(m_q),
    .done_o(mul_done), .p_o(mul_p)
  );

  mau_divmod #(.Width(Width)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .n_i(div_n), .d_i(div_d),
    .done_o(div_done), .q_o(div_qt), .r_o(div_r)
  );

  logic [Width-1:0] one_m, t_sub, inv_v, fin_x;
  logic             inv_on_a;
  assign one_m    = (m_q == Width'(1)) ? '0 : Width'(1);
  assign inv_on_a = (cmd_q == CMD_INVA) || (cmd_q == CMD_DIVB);
  assign inv_v    = inv_on_a ? a_q : b_q;
  assign fin_x    = inv_on_a ? b_q : a_q;
  // t0 - mul_p mod m
  assign t_sub    = (t0_q >= mul_p) ? (t0_q - mul_p) : (m_q - (mul_p - t0_q));

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);
  assign res_o.result     = DataWidth'(err_q ? '0 : acc_q);
  assign res_o.no_inverse = err_q;

  always_comb begin
    state_d   = state_q;
    mul_start = 1'b0;
    div_start = 1'b0;
    mul_x     = acc_q;
    mul_y     = base_q;
    div_n     = a_q;
    div_d     = m_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_RED_A;
        end
      end
      ST_RED_A: begin
        div_start = 1'b1;
        state_d   = ST_RED_B;
      end
      ST_RED_B: begin
        if (div_done) begin
          div_start = 1'b1;
          div_n     = b_q;
          state_d   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (div_done) begin
          state_d = ST_DONE;
          unique case (cmd_q) inside
            CMD_ADD, CMD_SUB: state_d = ST_DONE;
            CMD_MUL: begin
              mul_start = 1'b1;
              mul_x = a_q;
              mul_y = div_r;
              state_d = ST_FINAL_MUL;
            end
            CMD_POW: begin
              if (a_q != '0 && e_q != '0) begin
                state_d = ST_POW_MUL;
              end
            end
            default: state_d = ST_INV_DIV;
          endcase
        end
      end
      ST_POW_MUL: begin
        if (e_q == '0) begin
          state_d = ST_DONE;
        end else begin
          mul_start = 1'b1;
          state_d   = ST_POW_SQR;
        end
      end
      ST_POW_SQR: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_x     = base_q;
          state_d   = ST_FINAL_MUL;
        end
      end
      ST_INV_DIV: begin
        if (r1_q == '0) begin
          if (r0_q != Width'(1)) begin
            state_d = ST_DONE;
          end else if (cmd_q == CMD_INVA || cmd_q == CMD_INVB) begin
            state_d = ST_DONE;
          end else begin
            mul_start = 1'b1;
            mul_x     = fin_x;
            mul_y     = t0_q;
            state_d   = ST_FINAL_MUL;
          end
        end else begin
          div_start = 1'b1;
          div_n     = r0_q;
          div_d     = r1_q;
          state_d   = ST_INV_MUL;
        end
      end
      ST_INV_MUL: begin
        // reduce the quotient mod m as soon as it is out
        if (div_done) begin
          div_start = 1'b1;
          div_n     = div_qt;
          div_d     = m_q;
          state_d   = ST_INV_NEXT;
        end
      end
      ST_INV_NEXT: begin
        // multiply the reduced quotient by t1; hold here until the product is out
        if (div_done) begin
          mul_start = 1'b1;
          mul_x     = t1_q;
          mul_y     = div_r;
        end
      end
      ST_FINAL_MUL: begin
        if (mul_done) begin
          state_d = (cmd_q == CMD_POW) ? ST_POW_MUL : ST_DONE;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Inverse-loop multiply completion is tracked by a flag.
  logic inv_mul_q;

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_q <= cmd_e'(word_i.cmd);
          a_q   <= Width'(word_i.operand_a);
          b_q   <= Width'(word_i.operand_b);
          e_q   <= Width'(word_i.operand_b);
          m_q   <= (m_i == '0) ? Width'(1) : m_i;
          err_q <= 1'b0;
        end
      end
      ST_RED_B: begin
        if (div_done) begin
          a_q <= div_r;
        end
      end
      ST_DISPATCH: begin
        if (div_done) begin
          b_q    <= div_r;
          base_q <= a_q;
          r0_q   <= m_q;
          r1_q   <= ((cmd_q == CMD_INVA) || (cmd_q == CMD_DIVB)) ? a_q : div_r;
          t0_q   <= '0;
          t1_q   <= one_m;
          unique case (cmd_q)
            CMD_ADD: acc_q <= (a_q >= m_q - div_r) ? a_q - (m_q - div_r) : a_q + div_r;
            CMD_SUB: acc_q <= (a_q >= div_r) ? a_q - div_r : m_q - (div_r - a_q);
            CMD_POW: acc_q <= (a_q == '0) ? '0 : one_m;
            default: acc_q <= '0;
          endcase
        end
      end
      ST_POW_SQR: begin
        if (mul_done && e_q[0]) begin
          acc_q <= mul_p;
        end
        if (mul_done) begin
          e_q <= e_q >> 1;
        end
      end
      ST_INV_DIV: begin
        if (r1_q == '0) begin
          if (r0_q != Width'(1)) begin
            err_q <= 1'b1;
          end else begin
            acc_q <= t0_q;
          end
        end
      end
      ST_INV_MUL: begin
        if (div_done) begin
          r0_q <= r1_q;
          r1_q <= div_r;
        end
      end
      ST_FINAL_MUL: begin
        if (mul_done) begin
          if (cmd_q == CMD_POW) begin
            base_q <= mul_p;
          end else begin
            acc_q <= mul_p;
          end
        end
      end
      default: ;
    endcase
    if (inv_mul_q && mul_done) begin
      t0_q <= t1_q;
      t1_q <= t_sub;
    end
  end

  // Each pow step multiplies acc by base in ST_POW_MUL, keeps the product only for a
  // set exponent bit, then squares the base through ST_FINAL_MUL.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      inv_mul_q <= 1'b0;
    end else begin
      if (inv_mul_q) begin
        if (mul_done) begin
          inv_mul_q <= 1'b0;
          state_q   <= ST_INV_DIV;
        end
      end else begin
        state_q <= state_d;
        if (state_q == ST_INV_NEXT && div_done) begin
          inv_mul_q <= 1'b1;
        end
      end
    end
  end

endmodule

[hw/rtl/modular_arithmetic_unit_top.sv]
// Sequence from input accept to output valid: both operands are reduced by serial divides,
// then mul runs one serial multiply, pow two per exponent bit, and inverse two serial
// divides and one serial multiply per Euclid step; divide adds one more multiply.
// Throughput: one word at a time in the back end; a two-entry queue decouples input.
// Reset: asynchronous active low; modulus returns to 1, queue and output empty.
module modular_arithmetic_unit_top
  import mau_pkg::*;
#(
  parameter int unsigned WIDTH = DataWidth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [DataWidth-1:0] cfg_data_i
);

  // Modulus register, masked to WIDTH bits.
  logic [WIDTH-1:0] mod_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= WIDTH'(1);
    end else if (cfg_valid_i) begin
      mod_q <= WIDTH'(cfg_data_i);
    end
  end

  // Front: queue accepted words.
  logic     q_full, q_empty, q_rd, in_acc;
  in_word_t q_word, masked;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = q_full;
  always_comb begin
    masked           = in_data_i;
    masked.operand_a = DataWidth'(WIDTH'(in_data_i.operand_a));
    masked.operand_b = DataWidth'(WIDTH'(in_data_i.operand_b));
  end

  mau_fifo u_fifo (
    .clk_i, .rst_ni, .wr_i(in_acc), .wdata_i(masked), .full_o(q_full),
    .rd_i(q_rd), .empty_o(q_empty), .rdata_o(q_word)
  );

  // Back: one word through the core, result held in an output register.
  logic      core_busy, core_done;
  out_word_t core_res;
  logic      ov_q;
  assign q_rd = !q_empty && !core_busy && !ov_q;

  mau_core #(.Width(WIDTH)) u_core (
    .clk_i, .rst_ni, .start_i(q_rd), .word_i(q_word), .m_i(mod_q),
    .busy_o(core_busy), .done_o(core_done), .res_o(core_res)
  );

  always_ff @(posedge clk_i) begin
    if (core_done) begin
      out_data_o <= core_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (core_done) begin
      ov_q <= 1'b1;
    end else if (!out_stall_i) begin
      ov_q <= 1'b0;
    end
  end
  assign out_valid_o = ov_q;

  // Hold a stalled output word.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed under stall");
  // Never finish while a result is still pending.
  a_no_clobber: assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_done |-> !ov_q)
    else $error("result overwritten");
  // Error implies zero result.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.no_inverse |-> out_data_o.result == '0)
    else $error("no_inverse with nonzero result");

endmodule

[verif/modular_arithmetic_unit_top_tb.sv]
module modular_arithmetic_unit_top_tb;
  import mau_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Extra wait once no words are owed, before a modulus update and before the end of the run.
  localparam int unsigned DrainCycles = 64;

  typedef struct {
    logic [DataWidth-1:0] modulus;
    cmd_e                 cmd;
    logic [DataWidth-1:0] opa;
    logic [DataWidth-1:0] opb;
    bit                   typed;
    logic [DataWidth-1:0] res;
    logic                 noinv;
  } vector_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_word_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_word_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [DataWidth-1:0] cfg_data_i = '0;

  // Golden copy of the modulus register and the words still owed by the unit.
  logic [DataWidth-1:0] modulus_q = 1;
  out_word_t owed_words[$];
  int unsigned errors = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  always #2 clk_i = ~clk_i;

  modular_arithmetic_unit_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Arithmetic predictor. All operands but the pow exponent are already below m, which is
  // below 2^32, so 64-bit intermediates never overflow.
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] add_m(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    if (x >= m - y) begin
      return x - (m - y);
    end
    return x + y;
  endfunction

  function automatic logic [63:0] sub_m(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    if (x >= y) begin
      return x - y;
    end
    return m - (y - x);
  endfunction

  // Shift-and-add from the top bit, same order as the serial multiplier.
  function automatic logic [63:0] mul_m(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [63:0] acc;
    acc = 0;
    for (int i = 63; i >= 0; i--) begin
      acc = add_m(acc, acc, m);
      if (y[i]) begin
        acc = add_m(acc, x, m);
      end
    end
    return acc;
  endfunction

  function automatic logic [63:0] pow_m(logic [63:0] base, logic [63:0] expo, logic [63:0] m);
    logic [63:0] acc;
    acc = 1 % m;
    if (base == 0) begin
      return 0;
    end
    while (expo != 0) begin
      if (expo[0]) begin
        acc = mul_m(acc, base, m);
      end
      expo = expo >> 1;
      base = mul_m(base, base, m);
    end
    return acc;
  endfunction

  // Extended Euclid; only the coefficient of v is tracked, kept in [0, m).
  function automatic bit inv_m(logic [63:0] v, logic [63:0] m, output logic [63:0] inv);
    logic [63:0] r0, r1, r2, t0, t1, t2, q;
    r0 = m;
    r1 = v;
    t0 = 0;
    t1 = 1 % m;
    while (r1 != 0) begin
      q  = r0 / r1;
      r2 = r0 - q * r1;
      t2 = sub_m(t0, mul_m(q % m, t1, m), m);
      r0 = r1;
      r1 = r2;
      t0 = t1;
      t1 = t2;
    end
    inv = (r0 == 1) ? t0 : 0;
    return r0 == 1;
  endfunction

  function automatic out_word_t modular_result(in_word_t w, logic [DataWidth-1:0] modulus);
    logic [63:0] m, a, b, r, inv;
    bit ok;
    out_word_t o;
    // A zero modulus acts as one.
    m = (modulus == 0) ? 64'd1 : {32'd0, modulus};
    a = {32'd0, w.operand_a} % m;
    b = {32'd0, w.operand_b} % m;
    r = 0;
    ok = 1'b1;
    case (cmd_e'(w.cmd))
      CMD_ADD: r = add_m(a, b, m);
      CMD_SUB: r = sub_m(a, b, m);
      CMD_MUL: r = mul_m(a, b, m);
      // The exponent is taken at full width, not reduced.
      CMD_POW: r = pow_m(a, {32'd0, w.operand_b}, m);
      CMD_INVA: begin
        ok = inv_m(a, m, inv);
        r = inv;
      end
      CMD_INVB: begin
        ok = inv_m(b, m, inv);
        r = inv;
      end
      CMD_DIVA: begin
        ok = inv_m(b, m, inv);
        r = mul_m(a, inv, m);
      end
      default: begin
        ok = inv_m(a, m, inv);
        r = mul_m(b, inv, m);
      end
    endcase
    o.result = ok ? r[DataWidth-1:0] : '0;
    o.no_inverse = ~ok;
    return o;
  endfunction

  task automatic report_mismatch(input string what);
    errors++;
    $display("%0t ns: MISMATCH %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall, compare each accepted word with the oldest owed one.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word result=%h no_inverse=%b",
                                  out_data_o.result, out_data_o.no_inverse));
      end else begin
        want = owed_words.pop_front();
        if (out_data_o.result !== want.result) begin
          report_mismatch($sformatf("result %h, want %h", out_data_o.result, want.result));
        end
        if (out_data_o.no_inverse !== want.no_inverse) begin
          report_mismatch($sformatf("no_inverse %b, want %b",
                                    out_data_o.no_inverse, want.no_inverse));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. Called at a falling edge; returns at a falling edge with valid
  // still high so the next word can replace the payload without a glitch.
  // ---------------------------------------------------------------------------
  task automatic push_word(input in_word_t w, input bit typed, input out_word_t fixed);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    owed_words.push_back(typed ? fixed : modular_result(w, modulus_q));
    @(negedge clk_i);
  endtask

  // Write the modulus only with the unit drained; returns at a falling edge.
  task automatic set_modulus(input logic [DataWidth-1:0] value);
    in_valid_i <= 1'b0;
    while (owed_words.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DrainCycles) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    modulus_q = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Operand mix: extremes, small values and values straddling the modulus.
  function automatic logic [DataWidth-1:0] pick_operand();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 40);
      3: return modulus_q + $urandom_range(0, 4) - 2;
      default: return $urandom;
    endcase
  endfunction

  // Directed rows. Expected words are typed in only where they are obvious.
  vector_t directed[] = '{
    // Reset modulus of one: everything collapses to zero, inverses exist.
    '{32'd1, CMD_ADD,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'd0, 1'b0},
    '{32'd1, CMD_POW,  32'd0,         32'd0,         1, 32'd0, 1'b0},
    '{32'd1, CMD_INVA, 32'd0,         32'd5,         1, 32'd0, 1'b0},
    '{32'd1, CMD_DIVB, 32'hFFFF_FFFF, 32'd0,         1, 32'd0, 1'b0},
    // Zero modulus behaves as one.
    '{32'd0, CMD_MUL,  32'd12345,     32'd678,       1, 32'd0, 1'b0},
    '{32'd0, CMD_INVB, 32'd0,         32'd0,         1, 32'd0, 1'b0},
    // Small prime modulus.
    '{32'd13, CMD_ADD,  32'd12,        32'd12,        1, 32'd11, 1'b0},
    '{32'd13, CMD_SUB,  32'd0,         32'd1,         1, 32'd12, 1'b0},
    '{32'd13, CMD_MUL,  32'hFFFF_FFFF, 32'd2,         0, 32'd0,  1'b0},
    '{32'd13, CMD_POW,  32'd0,         32'd0,         1, 32'd0,  1'b0},
    '{32'd13, CMD_POW,  32'd13,        32'd5,         1, 32'd0,  1'b0},
    '{32'd13, CMD_POW,  32'd2,         32'd0,         1, 32'd1,  1'b0},
    '{32'd13, CMD_POW,  32'd2,         32'hFFFF_FFFF, 0, 32'd0,  1'b0},
    '{32'd13, CMD_INVA, 32'd0,         32'd3,         1, 32'd0,  1'b1},
    '{32'd13, CMD_INVB, 32'd5,         32'd26,        1, 32'd0,  1'b1},
    '{32'd13, CMD_INVA, 32'd2,         32'd0,         1, 32'd7,  1'b0},
    '{32'd13, CMD_DIVA, 32'd3,         32'd2,         0, 32'd0,  1'b0},
    '{32'd13, CMD_DIVB, 32'd2,         32'd3,         0, 32'd0,  1'b0},
    // Largest modulus; 2^32-1 shares the factor 3 with 3.
    '{32'hFFFF_FFFF, CMD_ADD,  32'hFFFF_FFFF, 32'hFFFF_FFFE, 0, 32'd0, 1'b0},
    '{32'hFFFF_FFFF, CMD_SUB,  32'd0,         32'hFFFF_FFFF, 0, 32'd0, 1'b0},
    '{32'hFFFF_FFFF, CMD_MUL,  32'hFFFF_FFFE, 32'hFFFF_FFFE, 0, 32'd0, 1'b0},
    '{32'hFFFF_FFFF, CMD_POW,  32'hFFFF_FFFE, 32'hFFFF_FFFF, 0, 32'd0, 1'b0},
    '{32'hFFFF_FFFF, CMD_INVA, 32'd3,         32'd1,         1, 32'd0, 1'b1},
    '{32'hFFFF_FFFF, CMD_INVB, 32'd1,         32'd2,         0, 32'd0, 1'b0},
    '{32'hFFFF_FFFF, CMD_DIVA, 32'h8000_0000, 32'd2,         0, 32'd0, 1'b0}
  };

  initial begin
    in_word_t w;
    out_word_t fixed;
    logic [DataWidth-1:0] moduli[5];

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part; the first rows run on the reset modulus, no write needed.
    foreach (directed[i]) begin
      if (directed[i].modulus != modulus_q) begin
        set_modulus(directed[i].modulus);
      end
      w.cmd = directed[i].cmd;
      w.operand_a = directed[i].opa;
      w.operand_b = directed[i].opb;
      fixed.result = directed[i].res;
      fixed.no_inverse = directed[i].noinv;
      push_word(w, directed[i].typed, fixed);
    end

    // Random part: three idle profiles, each sweeping several moduli.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct  = (phase == 0) ? 36 : (phase == 1) ? 67 : 0;
      stall_pct = (phase == 0) ? 67 : (phase == 1) ? 36 : 0;
      moduli = '{32'hFFFF_FFFB, $urandom_range(2, 1000), 32'd1, $urandom, 32'h8000_0000};
      if (phase == 2) begin
        moduli[2] = 32'd0;
      end
      foreach (moduli[k]) begin
        set_modulus(moduli[k]);
        repeat (16) begin
          w.cmd = 3'($urandom_range(7));
          w.operand_a = pick_operand();
          w.operand_b = pick_operand();
          // Keep most exponents short; long ones are slow.
          if (cmd_e'(w.cmd) == CMD_POW && $urandom_range(5) != 0) begin
            w.operand_b = $urandom_range(0, 255);
          end
          push_word(w, 1'b0, fixed);
        end
      end
    end
    in_valid_i <= 1'b0;

    while (owed_words.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("modular_arithmetic_unit_top test passed");
    end else begin
      $display("modular_arithmetic_unit_top test failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #40ms;
    $display("modular_arithmetic_unit_top test failed");
    $finish;
  end

endmodule
